FILE: src/sqt_pkg.sv
package sqt_pkg;

    // Quarter-wave table: entries 0 .. SINE_TABLE_DEPTH cover 0 .. pi/2.
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int ROM_AW           = $clog2(SINE_TABLE_DEPTH + 1);

    localparam int COORD_W = 24;   // Q16.8 coordinate
    localparam int SIZE_W  = 15;   // whole pixels
    localparam int ANGLE_W = 16;   // 65536 = one turn
    localparam int MAG_W   = 15;   // table magnitude, 0 .. 16384
    localparam int TRIG_W  = 16;   // signed Q2.14
    localparam int BOX_W   = 26;   // box corner, Q.8, before rotation
    localparam int PROD_W  = BOX_W + TRIG_W;   // Q.22 product
    localparam int ROT_W   = PROD_W - 13;      // rounded rotation, Q.8

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [BOX_W-1:0]   t_box;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [ROT_W-1:0]   t_rot;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin;
        logic signed [TRIG_W-1:0] cos;
    } t_trig;

    // Table entry i = sin(pi/2 * i / depth): Taylor series to x^17 in Q30,
    // truncating at each step, rounded half up to Q2.14 and clamped.
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 272; sum = sum + longint'(term);
        if (sum < 0) sum = 0;
        sum = (sum + 32768) / 65536;
        if (sum > 16384) sum = 16384;
        return sum[MAG_W-1:0];
    endfunction

endpackage

FILE: src/sqt_sine_rom.sv
module sqt_sine_rom (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [sqt_pkg::ANGLE_W-1:0]   i_angle,
    output sqt_pkg::t_trig                o_trig
);
    import sqt_pkg::*;

    localparam int IDX_PROD_W = 14 + ROM_AW;

    logic [MAG_W-1:0] rom [0:SINE_TABLE_DEPTH];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [MAG_W-1:0] ENTRY = sine_entry(g);
        assign rom[g] = ENTRY;
    end

    logic [1:0]            sin_quad;
    logic [1:0]            cos_quad;
    logic [IDX_PROD_W-1:0] idx_prod;
    logic [ROM_AW-1:0]     idx;
    logic [ROM_AW-1:0]     sin_addr;
    logic [ROM_AW-1:0]     cos_addr;

    logic [MAG_W-1:0] r_sin_mag;
    logic [MAG_W-1:0] r_cos_mag;
    logic             r_sin_neg;
    logic             r_cos_neg;

    // cosine is the sine a quarter turn on: same fraction, next quadrant
    always_comb begin
        sin_quad = i_angle[15:14];
        cos_quad = sin_quad + 2'd1;
        idx_prod = {{ROM_AW{1'b0}}, i_angle[13:0]} * IDX_PROD_W'(SINE_TABLE_DEPTH);
        idx      = idx_prod[IDX_PROD_W-1:14];
        sin_addr = sin_quad[0] ? ROM_AW'(SINE_TABLE_DEPTH) - idx : idx;
        cos_addr = cos_quad[0] ? ROM_AW'(SINE_TABLE_DEPTH) - idx : idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin_mag <= rom[sin_addr];
            r_cos_mag <= rom[cos_addr];
            r_sin_neg <= sin_quad[1];
            r_cos_neg <= cos_quad[1];
        end
    end

    always_comb begin
        o_trig.sin = r_sin_neg ? -$signed({1'b0, r_sin_mag}) : $signed({1'b0, r_sin_mag});
        o_trig.cos = r_cos_neg ? -$signed({1'b0, r_cos_mag}) : $signed({1'b0, r_cos_mag});
    end

endmodule

FILE: src/sprite_quad_transform_core.sv
// Rotated sprite quad corner setup.
// Input channel (i_valid / o_stall): one sprite request per beat, with
// position, pivot offset, texture size in pixels and angle in 1/65536 turn.
// Output channel (o_valid / i_stall): the four screen corners, left-bottom,
// left-top, right-top, right-bottom, as saturated signed Q16.8.
// A request accepted into stage 1 moves through stages 2 and 3 to stage 4,
// where o_valid stays high until the result is taken; throughput is one
// request per cycle while the receiver does not stall. Stage 1 reads sine and
// cosine from the quarter-wave table, stage 2 holds the eight corner-by-trig
// products, stage 3 the rounded rotated corners, stage 4 the translated,
// saturated result.
// Each stage carries its own valid bit and only holds while the stage after
// it is full and held, so bubbles close up and a stalled receiver does not
// stop the pipe until all four stages are occupied; o_stall rises only then.
// Results wait in the output register until taken, never dropped or repeated.
// Synchronous reset (i_rst_n low) empties all stages; the sine table is
// constant logic and needs no fill.
module sprite_quad_transform_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [sqt_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [sqt_pkg::COORD_W-1:0] i_pos_y,
    input  logic signed [sqt_pkg::COORD_W-1:0] i_origin_x,
    input  logic signed [sqt_pkg::COORD_W-1:0] i_origin_y,
    input  logic [sqt_pkg::SIZE_W-1:0]       i_sprite_width,
    input  logic [sqt_pkg::SIZE_W-1:0]       i_sprite_height,
    input  logic [sqt_pkg::ANGLE_W-1:0]      i_angle,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [sqt_pkg::COORD_W-1:0] o_corner0_x,
    output logic signed [sqt_pkg::COORD_W-1:0] o_corner0_y,
    output logic signed [sqt_pkg::COORD_W-1:0] o_corner1_x,
    output logic signed [sqt_pkg::COORD_W-1:0] o_corner1_y,
    output logic signed [sqt_pkg::COORD_W-1:0] o_corner2_x,
    output logic signed [sqt_pkg::COORD_W-1:0] o_corner2_y,
    output logic signed [sqt_pkg::COORD_W-1:0] o_corner3_x,
    output logic signed [sqt_pkg::COORD_W-1:0] o_corner3_y
);
    import sqt_pkg::*;

    localparam int SUM_W = ROT_W + 1;

    // Q.22 to Q.8: add half an LSB, floor (arithmetic shift)
    function automatic t_rot round_q22(input logic signed [PROD_W:0] v);
        logic signed [PROD_W:0] t;
        t = v + (PROD_W+1)'(8192);
        return t[PROD_W:14];
    endfunction

    function automatic t_coord sat_add(input t_rot r, input t_coord p);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(r) + SUM_W'(p);
        if (s > SUM_W'(8388607))       return t_coord'(24'sh7FFFFF);
        else if (s < -SUM_W'(8388608)) return t_coord'(24'sh800000);
        else                           return s[COORD_W-1:0];
    endfunction

    // stage readiness: a stage loads when empty or when it moves on
    logic rdy1, rdy2, rdy3, rdy4;
    logic r_v1, r_v2, r_v3, r_v4;

    assign rdy4    = !r_v4 || !i_stall;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;
    assign o_valid = r_v4;

    // ---- stage 1: table read, box corners ----
    t_trig  trig;
    t_box   n_left, n_right, n_bot, n_top;
    t_box   r_left1, r_right1, r_bot1, r_top1;
    t_coord r_px1, r_py1;

    sqt_sine_rom u_rom (
        .i_clk   (i_clk),
        .i_en    (rdy1),
        .i_angle (i_angle),
        .o_trig  (trig)
    );

    always_comb begin
        n_left  = -{{(BOX_W-COORD_W){i_origin_x[COORD_W-1]}}, i_origin_x};
        n_bot   = -{{(BOX_W-COORD_W){i_origin_y[COORD_W-1]}}, i_origin_y};
        n_right = n_left + $signed({{(BOX_W-SIZE_W-8){1'b0}}, i_sprite_width, 8'd0});
        n_top   = n_bot + $signed({{(BOX_W-SIZE_W-8){1'b0}}, i_sprite_height, 8'd0});
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_left1  <= n_left;
            r_right1 <= n_right;
            r_bot1   <= n_bot;
            r_top1   <= n_top;
            r_px1    <= i_pos_x;
            r_py1    <= i_pos_y;
        end
    end

    // ---- stage 2: eight products, exact Q.22 ----
    t_prod  r_lc2, r_ls2, r_rc2, r_rs2, r_bc2, r_bs2, r_tc2, r_ts2;
    t_coord r_px2, r_py2;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_lc2 <= r_left1  * trig.cos;
            r_ls2 <= r_left1  * trig.sin;
            r_rc2 <= r_right1 * trig.cos;
            r_rs2 <= r_right1 * trig.sin;
            r_bc2 <= r_bot1   * trig.cos;
            r_bs2 <= r_bot1   * trig.sin;
            r_tc2 <= r_top1   * trig.cos;
            r_ts2 <= r_top1   * trig.sin;
            r_px2 <= r_px1;
            r_py2 <= r_py1;
        end
    end

    // ---- stage 3: rotate and round ----
    // x = X*cos - Y*sin, y = X*sin + Y*cos
    t_rot   r_rx3 [4];
    t_rot   r_ry3 [4];
    t_coord r_px3, r_py3;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_rx3[0] <= round_q22((PROD_W+1)'(r_lc2) - (PROD_W+1)'(r_bs2));
            r_ry3[0] <= round_q22((PROD_W+1)'(r_ls2) + (PROD_W+1)'(r_bc2));
            r_rx3[1] <= round_q22((PROD_W+1)'(r_lc2) - (PROD_W+1)'(r_ts2));
            r_ry3[1] <= round_q22((PROD_W+1)'(r_ls2) + (PROD_W+1)'(r_tc2));
            r_rx3[2] <= round_q22((PROD_W+1)'(r_rc2) - (PROD_W+1)'(r_ts2));
            r_ry3[2] <= round_q22((PROD_W+1)'(r_rs2) + (PROD_W+1)'(r_tc2));
            r_rx3[3] <= round_q22((PROD_W+1)'(r_rc2) - (PROD_W+1)'(r_bs2));
            r_ry3[3] <= round_q22((PROD_W+1)'(r_rs2) + (PROD_W+1)'(r_bc2));
            r_px3    <= r_px2;
            r_py3    <= r_py2;
        end
    end

    // ---- stage 4: translate, saturate, output register ----
    t_coord r_cx4 [4];
    t_coord r_cy4 [4];

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            for (int k = 0; k < 4; k++) begin
                r_cx4[k] <= sat_add(r_rx3[k], r_px3);
                r_cy4[k] <= sat_add(r_ry3[k], r_py3);
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    assign o_corner0_x = r_cx4[0];
    assign o_corner0_y = r_cy4[0];
    assign o_corner1_x = r_cx4[1];
    assign o_corner1_y = r_cy4[1];
    assign o_corner2_x = r_cx4[2];
    assign o_corner2_y = r_cy4[2];
    assign o_corner3_x = r_cx4[3];
    assign o_corner3_y = r_cy4[3];

    // ---- checks ----
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && i_stall))
        else $error("input held off while the pipe has room");

    a_stage1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !rdy2) |=> (r_v1 && $stable(r_left1) && $stable(r_top1)))
        else $error("held stage 1 request overwritten");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule
